/* design/ttb_pkg.sv */
// Package: sizes, request codes and character codes of the text terminal buffer.
package ttb_pkg;

    // Buffer geometry
    localparam int ROWS   = 8;
    localparam int COLS   = 20;
    localparam int DEPTH  = ROWS * COLS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int CCOL_W = $clog2(COLS + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    // Field widths on the channels
    localparam int REQ_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int ARG_W   = 8;
    localparam int OCOL_W  = 5;
    localparam int OROW_W  = 6;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_NEWLINE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SETPOS  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd4;

    // Character codes
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] NULL_CODE    = 8'h00;

endpackage

/* design/ttb_if.sv */
// Interfaces: request and response channels of the text terminal buffer.
interface ttb_in_if import ttb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] char_code;
    logic [ARG_W-1:0]  col_arg;
    logic [ARG_W-1:0]  row_arg;

    modport source (output valid, output req_type, output char_code,
                    output col_arg, output row_arg, input ready);
    modport sink   (input valid, input req_type, input char_code,
                    input col_arg, input row_arg, output ready);
endinterface

interface ttb_out_if import ttb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] read_char;
    logic [OCOL_W-1:0] cursor_col;
    logic [OROW_W-1:0] cursor_row;

    modport source (output valid, output read_char, output cursor_col,
                    output cursor_row, input ready);
    modport sink   (input valid, input read_char, input cursor_col,
                    input cursor_row, output ready);
endinterface

/* design/text_terminal_buffer_top.sv */
// Top level: character text buffer with cursor, scroll, clear and cell read.
// Usage: requests arrive on i_req (valid/ready); each transfer yields exactly
// one response transfer on o_rsp carrying the read character (zero unless a
// read of an in-range cell) and the cursor column and row after the request.
// The text lives in one ROWS*COLS byte memory with a registered read.
// Lines scroll by moving a row base pointer; only the new top line is blanked.
// A request goes from idle to the done state, passing first through the sweep
// for newline (request or code 10), a write with wrap pending and clear, or
// through the read state for a read of an in-range cell; the done state
// loads the response register.
// The blanking sweep writes one cell per cycle through the single memory
// write port; scrolls and clear wait for that sweep to finish.
// The block works on one request at a time; a new request is taken as soon
// as the previous one has its response in the output register, so a stalled
// receiver holds only the response register and the request after it.
// Reset: after i_rst_n is released the block sweeps spaces into all
// ROWS*COLS cells with i_req.ready low, and homes the cursor. No response
// comes from that sweep.
module text_terminal_buffer_top import ttb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ttb_in_if.sink     i_req,
    ttb_out_if.source  o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_READ,
        S_DONE
    } t_state;

    // Map a logical row and column to a memory address through the row base.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col,
        input logic [ROW_W-1:0] base
    );
        logic [ROW_W:0]   sum;
        logic [ROW_W-1:0] phys;
        sum = {1'b0, row} + {1'b0, base};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            phys = ROW_W'(sum - (ROW_W+1)'(ROWS));
        end else begin
            phys = sum[ROW_W-1:0];
        end
        return ADDR_W'(phys * COLS) + ADDR_W'(col);
    endfunction

    t_state              r_state;
    logic [ROW_W-1:0]    r_base;
    logic [CCOL_W-1:0]   r_cur_col;
    logic [ROW_W-1:0]    r_cur_row;
    logic [ADDR_W-1:0]   r_cnt;
    logic [ADDR_W-1:0]   r_last;
    logic [CHAR_W-1:0]   r_fill_char;
    logic                r_emit;
    logic [CHAR_W-1:0]   r_res_char;
    logic [CHAR_W-1:0]   r_rd_data;
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic [OCOL_W-1:0]   r_out_col;
    logic [OROW_W-1:0]   r_out_row;

    logic [CHAR_W-1:0]   mem [DEPTH];

    logic                in_fire;
    logic                is_char;
    logic                is_scroll;
    logic                wrap;
    logic                rd_ok;
    logic                out_free;
    logic [ROW_W-1:0]    n_base;
    logic [ADDR_W-1:0]   n_row_start;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr_cur;
    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CHAR_W-1:0]   mem_wdata;

    assign i_req.ready = (r_state == S_IDLE);
    assign in_fire     = i_req.valid && i_req.ready;

    // Decode the request
    assign is_char   = (i_req.req_type == REQ_WRITE) && (i_req.char_code != NULL_CODE)
                       && (i_req.char_code != NEWLINE_CODE);
    assign wrap      = (r_cur_col >= CCOL_W'(COLS));
    assign is_scroll = (i_req.req_type == REQ_NEWLINE)
                       || ((i_req.req_type == REQ_WRITE) && (i_req.char_code == NEWLINE_CODE))
                       || (is_char && wrap);
    assign rd_ok     = (i_req.col_arg < ARG_W'(COLS)) && (i_req.row_arg < ARG_W'(ROWS));

    // New top line after a scroll is the physical row just before the current base (wrapping to the last row)
    assign n_base      = (r_base == '0) ? ROW_W'(ROWS - 1) : r_base - 1'b1;
    assign n_row_start = ADDR_W'(n_base * COLS);

    assign rd_addr     = cell_addr(ROW_W'(i_req.row_arg), COL_W'(i_req.col_arg), r_base);
    assign wr_addr_cur = cell_addr(r_cur_row, COL_W'(r_cur_col), r_base);

    // Memory port control: the sweep owns the write port while sweeping
    assign mem_we    = (r_state == S_SWEEP) || (in_fire && is_char && !wrap);
    assign mem_waddr = (r_state == S_SWEEP) ? r_cnt : wr_addr_cur;
    assign mem_wdata = (r_state == S_SWEEP) ? r_fill_char : i_req.char_code;
    assign mem_re    = in_fire && (i_req.req_type == REQ_READ) && rd_ok;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign out_free = !r_out_valid || o_rsp.ready;

    // Sequencer, cursor, row base and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_base      <= '0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_cnt       <= '0;
            r_last      <= ADDR_W'(DEPTH - 1);
            r_fill_char <= SPACE_CODE;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the response once taken, unless a new one loads this cycle
            if (r_out_valid && o_rsp.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_res_char <= NULL_CODE;
                        if (is_scroll) begin
                            // Rotate the base and blank the new top line;
                            // a wrapped write drops its character in column 0
                            r_base      <= n_base;
                            r_cnt       <= n_row_start;
                            r_last      <= n_row_start + ADDR_W'(COLS - 1);
                            r_fill_char <= is_char ? i_req.char_code : SPACE_CODE;
                            r_cur_col   <= is_char ? CCOL_W'(1) : '0;
                            r_cur_row   <= '0;
                            r_emit      <= 1'b1;
                            r_state     <= S_SWEEP;
                        end else begin
                            case (i_req.req_type)
                                REQ_WRITE: begin
                                    if (is_char) begin
                                        r_cur_col <= r_cur_col + 1'b1;
                                    end
                                    r_state <= S_DONE;
                                end
                                REQ_SETPOS: begin
                                    if (i_req.col_arg < ARG_W'(COLS)) begin
                                        r_cur_col <= CCOL_W'(i_req.col_arg);
                                    end
                                    if (i_req.row_arg < ARG_W'(ROWS)) begin
                                        r_cur_row <= ROW_W'(i_req.row_arg);
                                    end
                                    r_state <= S_DONE;
                                end
                                REQ_CLEAR: begin
                                    r_base      <= '0;
                                    r_cnt       <= '0;
                                    r_last      <= ADDR_W'(DEPTH - 1);
                                    r_fill_char <= SPACE_CODE;
                                    r_cur_col   <= '0;
                                    r_cur_row   <= '0;
                                    r_emit      <= 1'b1;
                                    r_state     <= S_SWEEP;
                                end
                                REQ_READ: begin
                                    r_state <= rd_ok ? S_READ : S_DONE;
                                end
                                default: begin
                                    r_state <= S_DONE;
                                end
                            endcase
                        end
                    end
                end
                S_SWEEP: begin
                    // Write one cell a cycle; only the first may carry a character
                    r_fill_char <= SPACE_CODE;
                    r_cnt       <= r_cnt + 1'b1;
                    if (r_cnt == r_last) begin
                        r_state <= r_emit ? S_DONE : S_IDLE;
                    end
                end
                S_READ: begin
                    r_res_char <= r_rd_data;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    // Hold until the response register frees up
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= r_res_char;
                        r_out_col   <= OCOL_W'(r_cur_col);
                        r_out_row   <= OROW_W'(r_cur_row);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_char  = r_out_char;
    assign o_rsp.cursor_col = r_out_col;
    assign o_rsp.cursor_row = r_out_row;

    // A transfer in always leaves idle, so no transfer on the next edge
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !i_req.ready)
        else $error("request transfer on two consecutive cycles");

    // Sweep counter never runs past the end of its range
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_cnt <= r_last))
        else $error("sweep counter beyond its last address");

    // Cursor row and column stay in range (column up to COLS, wrap pending)
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_row < ROW_W'(ROWS - 1)) || (r_cur_row == ROW_W'(ROWS - 1)))
        else $error("cursor row out of range");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_col <= CCOL_W'(COLS))
        else $error("cursor column out of range");

    // A response is loaded only when the register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_rsp.ready) |=> (r_state == S_DONE))
        else $error("response register overwritten while stalled");

endmodule
